@@ rtl/hsw_pkg.sv @@
// Shared types and constants for the heartbeat stall watchdog.
`timescale 1ns / 1ps

package hsw_pkg;

	localparam int TimeBits  = 40;
	localparam int CountBits = 8;
	localparam int AddrBits  = 5;
	localparam int DataBits  = 64;

	localparam logic [TimeBits-1:0]  ThresholdReset = TimeBits'(5000);
	localparam logic [TimeBits-1:0]  IntervalReset  = TimeBits'(10000);
	localparam logic [CountBits-1:0] MaxCountReset  = CountBits'(4);

	typedef enum logic [0:0] {
		OP_HEARTBEAT = 1'b0,
		OP_POLL      = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_SAMPLE    = 2'd1,
		KIND_RECOVERED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_INTERVAL  = 2'd1,
		REG_MAX_COUNT = 2'd2
	} reg_idx_t;

endpackage

@@ rtl/heartbeat_stall_watchdog.sv @@
// Heartbeat stall watchdog: input stage, decision logic, result register and APB registers.
//
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     operation, now_ms, suppress
// result    out        result_valid / result_stall report_kind, stalled_ms, sample_number,
//                                                  recovered_after_ms
// apb       in         psel, penable, pwrite       paddr, pwdata, prdata (pready tied high)
//
// One item per cycle unless results stall; results register as items leave the input stage.
// The watchdog state is updated when the item leaves the input stage, so the next item
// in that stage already sees it.
// A stalled result holds the input stage; the item channel stalls only while that stage is full.
// Reset disarms the watchdog and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module heartbeat_stall_watchdog (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 operation,
	input  logic [hsw_pkg::TimeBits-1:0]         now_ms,
	input  logic                                 suppress,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [1:0]                           report_kind,
	output logic [hsw_pkg::TimeBits-1:0]         stalled_ms,
	output logic [hsw_pkg::CountBits-1:0]        sample_number,
	output logic [hsw_pkg::TimeBits-1:0]         recovered_after_ms,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [hsw_pkg::AddrBits-1:0]         paddr,
	input  logic [hsw_pkg::DataBits-1:0]         pwdata,
	output logic [hsw_pkg::DataBits-1:0]         prdata,
	output logic                                 pready
);

	localparam int TB = hsw_pkg::TimeBits;
	localparam int CB = hsw_pkg::CountBits;

	// Configuration registers
	logic [TB-1:0] threshold_q;
	logic [TB-1:0] interval_q;
	logic [CB-1:0] max_count_q;
	hsw_pkg::reg_idx_t reg_idx;
	logic          cfg_write;

	// Watchdog state
	logic [TB-1:0] last_beat_q;
	logic          in_stall_q;
	logic [TB-1:0] origin_q;
	logic [TB-1:0] next_time_q;
	logic [CB-1:0] count_q;

	// Input stage
	logic          valid_s1;
	logic          op_s1;
	logic [TB-1:0] now_s1;
	logic          sup_s1;

	// Result register
	logic          res_valid_q;
	hsw_pkg::kind_t kind_q;
	logic [TB-1:0] stalled_q;
	logic [CB-1:0] number_q;
	logic [TB-1:0] recov_q;

	logic          advance;
	logic          take;

	// Next-state and result values
	hsw_pkg::kind_t kind_d;
	logic [TB-1:0] stalled_d;
	logic [CB-1:0] number_d;
	logic [TB-1:0] recov_d;
	logic [TB-1:0] last_beat_d;
	logic          in_stall_d;
	logic [TB-1:0] origin_d;
	logic [TB-1:0] next_time_d;
	logic [CB-1:0] count_d;

	logic [TB-1:0] age;
	logic [TB:0]   next_sum;
	logic [TB-1:0] next_sat;
	logic [CB-1:0] eff_count;
	logic [TB-1:0] eff_next;
	logic [CB-1:0] count_inc;

	assign advance    = valid_s1 && !(res_valid_q && result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	assign result_valid       = res_valid_q;
	assign report_kind        = kind_q;
	assign stalled_ms         = stalled_q;
	assign sample_number      = number_q;
	assign recovered_after_ms = recov_q;

	assign pready    = 1'b1;
	assign reg_idx   = hsw_pkg::reg_idx_t'(paddr[4:3]);
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			hsw_pkg::REG_THRESHOLD: prdata = {{(hsw_pkg::DataBits-TB){1'b0}}, threshold_q};
			hsw_pkg::REG_INTERVAL:  prdata = {{(hsw_pkg::DataBits-TB){1'b0}}, interval_q};
			hsw_pkg::REG_MAX_COUNT: prdata = {{(hsw_pkg::DataBits-CB){1'b0}}, max_count_q};
			default:                prdata = '0;
		endcase
	end

	assign age       = (now_s1 > last_beat_q) ? (now_s1 - last_beat_q) : '0;
	assign next_sum  = {1'b0, now_s1} + {1'b0, interval_q};
	assign next_sat  = next_sum[TB] ? {TB{1'b1}} : next_sum[TB-1:0];
	assign eff_count = in_stall_q ? count_q : '0;
	assign eff_next  = in_stall_q ? next_time_q : now_s1;
	assign count_inc = eff_count + CB'(1);

	always_comb begin
		kind_d      = hsw_pkg::KIND_NONE;
		stalled_d   = '0;
		number_d    = '0;
		recov_d     = '0;
		last_beat_d = last_beat_q;
		in_stall_d  = in_stall_q;
		origin_d    = origin_q;
		next_time_d = next_time_q;
		count_d     = count_q;
		if (op_s1 == hsw_pkg::OP_HEARTBEAT) begin
			last_beat_d = now_s1;
		end else if (last_beat_q == '0) begin
			// Not armed: nothing to report, nothing changes.
		end else if (in_stall_q && last_beat_q != origin_q) begin
			in_stall_d = 1'b0;
			kind_d     = hsw_pkg::KIND_RECOVERED;
			recov_d    = last_beat_q - origin_q;
		end else if (age >= threshold_q && !sup_s1) begin
			in_stall_d = 1'b1;
			if (!in_stall_q) begin
				origin_d = last_beat_q;
			end
			if (eff_count < max_count_q && now_s1 >= eff_next) begin
				count_d     = count_inc;
				next_time_d = next_sat;
				kind_d      = hsw_pkg::KIND_SAMPLE;
				stalled_d   = age;
				number_d    = count_inc;
			end else begin
				count_d     = eff_count;
				next_time_d = eff_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= hsw_pkg::ThresholdReset;
			interval_q  <= hsw_pkg::IntervalReset;
			max_count_q <= hsw_pkg::MaxCountReset;
			last_beat_q <= '0;
			in_stall_q  <= 1'b0;
			origin_q    <= '0;
			next_time_q <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (reg_idx)
					hsw_pkg::REG_THRESHOLD: threshold_q <= pwdata[TB-1:0];
					hsw_pkg::REG_INTERVAL:  interval_q  <= pwdata[TB-1:0];
					hsw_pkg::REG_MAX_COUNT: max_count_q <= pwdata[CB-1:0];
					default: ;
				endcase
			end
			if (advance) begin
				last_beat_q <= last_beat_d;
				in_stall_q  <= in_stall_d;
				origin_q    <= origin_d;
				next_time_q <= next_time_d;
				count_q     <= count_d;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= operation;
			now_s1 <= now_ms;
			sup_s1 <= suppress;
		end
		if (advance) begin
			kind_q    <= kind_d;
			stalled_q <= stalled_d;
			number_q  <= number_d;
			recov_q   <= recov_d;
		end
	end

	// A sample leaves an open stall with a nonzero count behind it.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_d == hsw_pkg::KIND_SAMPLE |=> in_stall_q && count_q != '0)
		else $error("sample issued without an open stall");

	// Recovery closes the stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_d == hsw_pkg::KIND_RECOVERED |=> !in_stall_q)
		else $error("stall still open after recovery");

	// The item channel stalls only while the input stage holds a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && res_valid_q && result_stall)
		else $error("item stall without a blocked input stage");

	// Only a sample carries a sample number.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && kind_q != hsw_pkg::KIND_SAMPLE |-> number_q == '0)
		else $error("sample number on a non-sample result");

endmodule

@@ tb/heartbeat_stall_watchdog_tb.sv @@
// Self-checking testbench for the heartbeat stall watchdog with a built-in stall predictor.
`timescale 1ns / 1ps

module heartbeat_stall_watchdog_tb;

	localparam int TimeBits  = hsw_pkg::TimeBits;
	localparam int CountBits = hsw_pkg::CountBits;
	localparam int AddrBits  = hsw_pkg::AddrBits;
	localparam int DataBits  = hsw_pkg::DataBits;

	localparam logic [TimeBits-1:0] MaxTime    = '1;
	localparam int unsigned         CycleLimit = 200000;

	typedef struct packed {
		hsw_pkg::kind_t       kind;
		logic [TimeBits-1:0]  stalled;
		logic [CountBits-1:0] number;
		logic [TimeBits-1:0]  recovered;
	} report_t;

	class stall_report_board;
		logic [TimeBits-1:0]  threshold;
		logic [TimeBits-1:0]  interval;
		logic [CountBits-1:0] max_count;
		logic [TimeBits-1:0]  beat;
		logic [TimeBits-1:0]  origin;
		logic [TimeBits-1:0]  next_at;
		logic                 in_stall;
		logic [CountBits-1:0] count;
		report_t              pending_reports[$];
		int                   mismatches;

		function new();
			threshold  = hsw_pkg::ThresholdReset;
			interval   = hsw_pkg::IntervalReset;
			max_count  = hsw_pkg::MaxCountReset;
			beat       = '0;
			origin     = '0;
			next_at    = '0;
			in_stall   = 1'b0;
			count      = '0;
			mismatches = 0;
		endfunction

		function void write_reg(hsw_pkg::reg_idx_t idx, logic [DataBits-1:0] value);
			case (idx)
				hsw_pkg::REG_THRESHOLD: threshold = value[TimeBits-1:0];
				hsw_pkg::REG_INTERVAL:  interval  = value[TimeBits-1:0];
				hsw_pkg::REG_MAX_COUNT: max_count = value[CountBits-1:0];
				default: ;
			endcase
		endfunction

		function void predict(hsw_pkg::op_t op, logic [TimeBits-1:0] now, logic sup);
			report_t            r;
			logic [TimeBits-1:0] age;
			logic [TimeBits:0]   sum;
			r = '0;
			r.kind = hsw_pkg::KIND_NONE;
			if (op == hsw_pkg::OP_HEARTBEAT) begin
				beat = now;
			end else if (beat != '0) begin
				age = (now > beat) ? now - beat : '0;
				if (in_stall && beat != origin) begin
					// The beat has moved since the stall began; a backwards move wraps.
					in_stall    = 1'b0;
					r.kind      = hsw_pkg::KIND_RECOVERED;
					r.recovered = beat - origin;
				end else if (age >= threshold && !sup) begin
					if (!in_stall) begin
						in_stall = 1'b1;
						origin   = beat;
						count    = '0;
						next_at  = now;
					end
					if (count < max_count && now >= next_at) begin
						count   = count + CountBits'(1);
						sum     = {1'b0, now} + {1'b0, interval};
						next_at = sum[TimeBits] ? MaxTime : sum[TimeBits-1:0];
						r.kind    = hsw_pkg::KIND_SAMPLE;
						r.stalled = age;
						r.number  = count;
					end
				end
			end
			pending_reports.push_back(r);
		endfunction

		function int outstanding();
			return pending_reports.size();
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t: result with none expected: kind %0d", $time, got.kind);
				mismatches++;
				return;
			end
			want = pending_reports.pop_front();
			if (got.kind != want.kind) begin
				$display("%0t: report_kind expected %0d, got %0d", $time, want.kind, got.kind);
				mismatches++;
			end
			if (got.stalled != want.stalled) begin
				$display("%0t: stalled_ms expected %0d, got %0d",
					$time, want.stalled, got.stalled);
				mismatches++;
			end
			if (got.number != want.number) begin
				$display("%0t: sample_number expected %0d, got %0d",
					$time, want.number, got.number);
				mismatches++;
			end
			if (got.recovered != want.recovered) begin
				$display("%0t: recovered_after_ms expected %0d, got %0d",
					$time, want.recovered, got.recovered);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic                 operation = 1'b0;
	logic [TimeBits-1:0]  now_ms = '0;
	logic                 suppress = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [1:0]           report_kind;
	logic [TimeBits-1:0]  stalled_ms;
	logic [CountBits-1:0] sample_number;
	logic [TimeBits-1:0]  recovered_after_ms;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [AddrBits-1:0]  paddr = '0;
	logic [DataBits-1:0]  pwdata = '0;
	logic [DataBits-1:0]  prdata;
	logic                 pready;

	stall_report_board board = new();
	bit                quiet = 1'b0;
	int unsigned       cycle_count = 0;

	heartbeat_stall_watchdog i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.operation          (operation),
		.now_ms             (now_ms),
		.suppress           (suppress),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.report_kind        (report_kind),
		.stalled_ms         (stalled_ms),
		.sample_number      (sample_number),
		.recovered_after_ms (recovered_after_ms),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= quiet ? 1'b0 : ($urandom_range(99) < 12);
	end

	always @(posedge clk) begin
		report_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.kind      = hsw_pkg::kind_t'(report_kind);
			got.stalled   = stalled_ms;
			got.number    = sample_number;
			got.recovered = recovered_after_ms;
			board.check_report(got);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("** heartbeat_stall_watchdog: FAILED **");
			$finish;
		end
	end

	// Entered and left at a falling edge.
	task automatic offer_item(hsw_pkg::op_t op, logic [TimeBits-1:0] t, logic sup);
		while (!quiet && $urandom_range(99) < 12) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		operation  <= op;
		now_ms     <= t;
		suppress   <= sup;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		board.predict(op, t, sup);
		@(negedge clk);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (board.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(hsw_pkg::reg_idx_t idx, logic [DataBits-1:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.write_reg(idx, value);
		@(negedge clk);
	endtask

	// Mostly a steadily advancing clock with beats and polls, plus some arbitrary transactions.
	task automatic run_phase(logic [TimeBits-1:0] thr, logic [TimeBits-1:0] intv,
			logic [CountBits-1:0] maxc, logic [TimeBits-1:0] start, int unsigned step,
			int unsigned hb_pct, int unsigned noise_pct, int unsigned items, bit calm);
		logic [TimeBits-1:0] clock_ms;
		logic [TimeBits-1:0] t;
		logic [TimeBits:0]   sum;
		hsw_pkg::op_t        op;
		logic                sup;
		settle();
		apb_write(hsw_pkg::REG_THRESHOLD, DataBits'(thr));
		apb_write(hsw_pkg::REG_INTERVAL, DataBits'(intv));
		apb_write(hsw_pkg::REG_MAX_COUNT, DataBits'(maxc));
		quiet    = calm;
		clock_ms = start;
		repeat (items) begin
			if ($urandom_range(99) < noise_pct) begin
				op  = hsw_pkg::op_t'($urandom_range(1));
				t   = {8'($urandom()), 32'($urandom())};
				sup = 1'($urandom_range(1));
				if ($urandom_range(9) == 0) t = '0;
			end else begin
				op  = ($urandom_range(99) < hb_pct) ? hsw_pkg::OP_HEARTBEAT : hsw_pkg::OP_POLL;
				t   = clock_ms;
				sup = ($urandom_range(99) < 10);
				sum = {1'b0, clock_ms} + (TimeBits+1)'($urandom_range(step));
				clock_ms = sum[TimeBits] ? MaxTime : sum[TimeBits-1:0];
			end
			offer_item(op, t, sup);
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Register defaults straight out of reset.
		offer_item(hsw_pkg::OP_POLL, TimeBits'(1000), 1'b0);
		offer_item(hsw_pkg::OP_HEARTBEAT, TimeBits'(0), 1'b1);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(9000), 1'b0);
		offer_item(hsw_pkg::OP_HEARTBEAT, TimeBits'(1000), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(5999), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(6000), 1'b1);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(6000), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(15999), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(16000), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(26000), 1'b1);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(26000), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(36000), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(46000), 1'b0);
		// Disarm with the stall still open, then re-arm with an earlier beat.
		offer_item(hsw_pkg::OP_HEARTBEAT, TimeBits'(0), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(50000), 1'b0);
		offer_item(hsw_pkg::OP_HEARTBEAT, TimeBits'(900), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(50001), 1'b1);
		offer_item(hsw_pkg::OP_HEARTBEAT, TimeBits'(60000), 1'b0);
		offer_item(hsw_pkg::OP_POLL, TimeBits'(59000), 1'b0);
		// At the top of the time range the next sample time saturates.
		offer_item(hsw_pkg::OP_HEARTBEAT, MaxTime - TimeBits'(10000), 1'b0);
		offer_item(hsw_pkg::OP_POLL, MaxTime, 1'b0);
		offer_item(hsw_pkg::OP_POLL, MaxTime, 1'b0);
		offer_item(hsw_pkg::OP_HEARTBEAT, MaxTime, 1'b1);
		offer_item(hsw_pkg::OP_POLL, MaxTime, 1'b1);

		run_phase(TimeBits'(100), TimeBits'(250), CountBits'(3), TimeBits'(1000),
			60, 20, 15, 150, 1'b0);
		// Zero threshold and interval: every unsuppressed poll samples until the count runs out.
		run_phase(TimeBits'(0), TimeBits'(0), CountBits'(255), TimeBits'(5),
			3, 0, 0, 280, 1'b0);
		run_phase(MaxTime, MaxTime, CountBits'(0), TimeBits'(40'h10_0000),
			1000, 20, 15, 120, 1'b1);
		run_phase(TimeBits'(40), MaxTime, CountBits'(2), MaxTime - TimeBits'(3000),
			20, 15, 15, 120, 1'b0);
		run_phase(TimeBits'(1), TimeBits'(5), CountBits'(1), TimeBits'(100),
			4, 25, 15, 110, 1'b0);
		run_phase(hsw_pkg::ThresholdReset, hsw_pkg::IntervalReset, hsw_pkg::MaxCountReset,
			TimeBits'(0), 3000, 15, 15, 120, 1'b0);

		settle();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("** heartbeat_stall_watchdog: PASSED **");
		end else begin
			$display("** heartbeat_stall_watchdog: FAILED **");
		end
		$finish;
	end

endmodule
